// ----- rtl/tchc_pkg.sv -----
// ============================================================================
// tchc_pkg: shared types and constants of the time/channel hit clusterer
// Cluster record, cell and bank command types, sizes and register indexes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tchc_pkg;

    // sizes
    localparam int MAX_OPEN    = 16;
    localparam int MAX_MEMBERS = 32;
    localparam int SLOT_W      = $clog2(MAX_OPEN);
    localparam int ADDR_W      = $clog2(MAX_MEMBERS);
    localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);

    // field widths
    localparam int TIME_W     = 48;
    localparam int DUR_W      = 16;
    localparam int CHAN_W     = 14;
    localparam int ADC_W      = 24;
    localparam int SUM_W      = 32;
    localparam int HITS_W     = 8;
    localparam int DROP_W     = 16;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_GAP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_GAP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ADC_CUT  = CFG_IDX_W'(3);

    // one open cluster; bank names the channel store that belongs to it
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [HITS_W-1:0] hits;
        logic [SUM_W-1:0]  adc_sum;
        logic [CHAN_W-1:0] chan_low;
        logic [CHAN_W-1:0] chan_high;
        logic              ovf;
        logic [SLOT_W-1:0] bank;
    } cluster_rec_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_TAKE_PREV,
        CELL_TAKE_NEXT,
        CELL_LOAD,
        CELL_ABSORB,
        CELL_KILL,
        CELL_SET_OVF
    } cell_op_t;

    typedef struct packed {
        logic scan_clr;
        logic scan_en;
        logic append;
        logic init;
    } bank_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/time_channel_hit_clusterer_unit.sv -----
// ============================================================================
// time_channel_hit_clusterer_unit: time and channel clustering of hits
// Groups time-sorted hits into up to MAX_OPEN open clusters and emits
// summaries of the clusters it closes that meet min hits and the ADC cut.
// ============================================================================
// Usage:
//  - Input channel (in_valid/in_ready): one beat per hit or flush. in_ready
//    is high only while the block is idle; one item is worked at a time.
//  - Output channel (out_valid/out_ready): one beat per emitted cluster,
//    oldest first; last_of_run marks the final beat caused by an item.
//  - Config channel (cfg_valid/cfg_ready): always ready; write only while idle.
//  - A hit passes the member scan (one channel per cycle, all banks in
//    parallel), the age-order emit walk, the join and any merges, the
//    odd-even compaction of the cell chain and allocation. A flush skips
//    the scan, the join and allocation.
//  - A stalled receiver holds the emit walk; nothing is lost.
//  - Reset clears all open clusters, the drop count and the config registers.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module time_channel_hit_clusterer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tchc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tchc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [tchc_pkg::TIME_W-1:0]       hit_start,
    input  logic [tchc_pkg::DUR_W-1:0]        hit_duration,
    input  logic [tchc_pkg::CHAN_W-1:0]       hit_channel,
    input  logic [tchc_pkg::ADC_W-1:0]        hit_adc,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tchc_pkg::HITS_W-1:0]       member_count,
    output logic [tchc_pkg::SUM_W-1:0]        adc_total,
    output logic [tchc_pkg::TIME_W-1:0]       first_time,
    output logic [tchc_pkg::TIME_W-1:0]       last_time,
    output logic [tchc_pkg::CHAN_W-1:0]       channel_low,
    output logic [tchc_pkg::CHAN_W-1:0]       channel_high,
    output logic                              store_overflow,
    output logic [tchc_pkg::DROP_W-1:0]       dropped_hits,
    output logic                              last_of_run
);
    import tchc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_SCAN    = 10'b0000000010,
        S_DRAIN   = 10'b0000000100,
        S_DECIDE  = 10'b0000001000,
        S_EMIT    = 10'b0000010000,
        S_HIT     = 10'b0000100000,
        S_MERGE   = 10'b0001000000,
        S_COPY    = 10'b0010000000,
        S_COMPACT = 10'b0100000000,
        S_ALLOC   = 10'b1000000000
    } state_t;

    function automatic logic [SLOT_W-1:0] first_set(input logic [MAX_OPEN-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int k = MAX_OPEN - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                idx = SLOT_W'(k);
            end
        end
        return idx;
    endfunction

    // configuration registers
    logic [TICK_W-1:0] tick_reg;
    logic [CHAN_W-1:0] chan_gap_reg;
    logic [HITS_W-1:0] min_hits_reg;
    logic [SUM_W-1:0]  adc_cut_reg;

    // item registers
    logic              flush_reg;
    logic [TIME_W-1:0] hs_reg;
    logic [TIME_W-1:0] end_reg;
    logic [CHAN_W-1:0] ch_reg;
    logic [ADC_W-1:0]  adc_reg;
    logic [TIME_W:0]   end_sum;

    // sequencer
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   j_reg, j_next;
    logic [SLOT_W-1:0]   p_reg, p_next;
    logic [SLOT_W-1:0]   cmp_reg, cmp_next;
    logic [MAX_OPEN-1:0] close_mask_reg, close_mask_next;
    logic [MAX_OPEN-1:0] near_mask_reg, near_mask_next;
    logic [MAX_OPEN-1:0] emit_mask_reg, emit_mask_next;
    logic [MAX_OPEN-1:0] src_mask_reg, src_mask_next;
    logic [SLOT_W-1:0]   tgt_reg, tgt_next;
    logic [SLOT_W-1:0]   tgt_bank_reg, tgt_bank_next;
    logic [SLOT_W-1:0]   src_reg, src_next;
    logic [SLOT_W-1:0]   src_bank_reg, src_bank_next;
    logic                joined_reg, joined_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic                pend_reg, pend_next;
    logic [DROP_W-1:0]   drop_reg, drop_next;
    logic                out_valid_reg, out_valid_next;
    logic                emit_fire;
    logic                emit_last;
    logic [MAX_OPEN-1:0] emit_rest;
    logic                in_fire;

    // output registers
    cluster_rec_t      out_rec_reg;
    logic [DROP_W-1:0] out_drop_reg;
    logic              out_last_reg;

    // cell chain and banks
    cluster_rec_t        cell_rec  [MAX_OPEN];
    cluster_rec_t        prev_rec  [MAX_OPEN];
    cluster_rec_t        next_rec  [MAX_OPEN];
    cell_op_t            cell_op   [MAX_OPEN];
    bank_cmd_t           bank_cmd  [MAX_OPEN];
    logic [CHAN_W-1:0]   bank_rdata  [MAX_OPEN];
    logic [CNT_W-1:0]    bank_stored [MAX_OPEN];
    logic [MAX_OPEN-1:0] bank_near, bank_full;
    logic [MAX_OPEN-1:0] close_vec, qual_vec, near_vec, valid_vec;
    logic [MAX_OPEN-1:0] bank_used;
    cluster_rec_t        load_rec, hit_rec;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CHAN_W-1:0]   wr_data;
    logic [SLOT_W-1:0]   sel_a;
    logic                copy_issue;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            chan_gap_reg <= '0;
            min_hits_reg <= '0;
            adc_cut_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TICK_GAP: tick_reg     <= cfg_data[TICK_W-1:0];
                REG_CHAN_GAP: chan_gap_reg <= cfg_data[CHAN_W-1:0];
                REG_MIN_HITS: min_hits_reg <= cfg_data[HITS_W-1:0];
                REG_ADC_CUT:  adc_cut_reg  <= cfg_data[SUM_W-1:0];
                default:      ;
            endcase
        end
    end

    // item capture, hit end saturates at the top of the time range
    assign end_sum = {1'b0, hit_start} + (TIME_W+1)'(hit_duration);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            flush_reg <= req_type;
            hs_reg    <= hit_start;
            end_reg   <= end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
            ch_reg    <= hit_channel;
            adc_reg   <= hit_adc;
        end
    end

    always_comb
    begin
        hit_rec            = '0;
        hit_rec.valid      = 1'b1;
        hit_rec.start_time = hs_reg;
        hit_rec.end_time   = end_reg;
        hit_rec.hits       = HITS_W'(1);
        hit_rec.adc_sum    = SUM_W'(adc_reg);
        hit_rec.chan_low   = ch_reg;
        hit_rec.chan_high  = ch_reg;
    end

    // cell chain and channel banks
    for (genvar g = 0; g < MAX_OPEN; g++)
    begin : g_slot
        if (g == 0)
        begin : g_first
            assign prev_rec[g] = '0;
        end
        else
        begin : g_inner_prev
            assign prev_rec[g] = cell_rec[g-1];
        end
        if (g == MAX_OPEN - 1)
        begin : g_last
            assign next_rec[g] = '0;
        end
        else
        begin : g_inner_next
            assign next_rec[g] = cell_rec[g+1];
        end

        tchc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .reset_bank (SLOT_W'(g)),
            .op         (cell_op[g]),
            .load_rec   (load_rec),
            .prev_rec   (prev_rec[g]),
            .next_rec   (next_rec[g]),
            .hit_start  (hs_reg),
            .tick_gap   (tick_reg),
            .min_hits   (min_hits_reg),
            .adc_cut    (adc_cut_reg),
            .bank_near  (bank_near),
            .rec        (cell_rec[g]),
            .closing    (close_vec[g]),
            .qualified  (qual_vec[g]),
            .near       (near_vec[g])
        );

        tchc_bank u_bank (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (bank_cmd[g]),
            .rd_addr     (rd_addr),
            .wr_data     (wr_data),
            .hit_channel (ch_reg),
            .chan_gap    (chan_gap_reg),
            .rd_data     (bank_rdata[g]),
            .near        (bank_near[g]),
            .full        (bank_full[g]),
            .stored      (bank_stored[g])
        );

        assign valid_vec[g] = cell_rec[g].valid;
    end

    // last beat of the run: no emit left above the current position
    assign emit_rest = emit_mask_reg >> p_reg;
    assign emit_last = ((emit_rest >> 1) == '0);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        j_next          = j_reg;
        p_next          = p_reg;
        cmp_next        = cmp_reg;
        close_mask_next = close_mask_reg;
        near_mask_next  = near_mask_reg;
        emit_mask_next  = emit_mask_reg;
        src_mask_next   = src_mask_reg;
        tgt_next        = tgt_reg;
        tgt_bank_next   = tgt_bank_reg;
        src_next        = src_reg;
        src_bank_next   = src_bank_reg;
        joined_next     = joined_reg;
        i_next          = i_reg;
        len_next        = len_reg;
        pend_next       = 1'b0;
        drop_next       = drop_reg;
        emit_fire       = 1'b0;
        load_rec        = hit_rec;
        rd_addr         = j_reg;
        wr_data         = ch_reg;
        sel_a           = '0;
        copy_issue      = 1'b0;
        for (int k = 0; k < MAX_OPEN; k++)
        begin
            cell_op[k]  = CELL_HOLD;
            bank_cmd[k] = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                        j_next     = '0;
                        for (int k = 0; k < MAX_OPEN; k++)
                        begin
                            bank_cmd[k].scan_clr = 1'b1;
                        end
                    end
                end
            end

            // every bank walks its stored channels
            S_SCAN:
            begin
                rd_addr = j_reg;
                for (int k = 0; k < MAX_OPEN; k++)
                begin
                    bank_cmd[k].scan_en = 1'b1;
                end
                if (j_reg == ADDR_W'(MAX_MEMBERS - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + ADDR_W'(1);
                end
            end

            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end

            // freeze close, join and emit sets
            S_DECIDE:
            begin
                close_mask_next = flush_reg ? valid_vec : close_vec;
                near_mask_next  = flush_reg ? '0 : (near_vec & ~close_vec);
                emit_mask_next  = (flush_reg ? valid_vec : close_vec) & qual_vec;
                p_next          = '0;
                state_next      = S_EMIT;
            end

            // closed clusters leave oldest first
            S_EMIT:
            begin
                if (!emit_mask_reg[p_reg] || !out_valid_reg || out_ready)
                begin
                    emit_fire = emit_mask_reg[p_reg];
                    if (p_reg == SLOT_W'(MAX_OPEN - 1))
                    begin
                        for (int k = 0; k < MAX_OPEN; k++)
                        begin
                            if (close_mask_reg[k])
                            begin
                                cell_op[k] = CELL_KILL;
                            end
                        end
                        cmp_next   = '0;
                        state_next = flush_reg ? S_COMPACT : S_HIT;
                    end
                    else
                    begin
                        p_next = p_reg + SLOT_W'(1);
                    end
                end
            end

            // hit joins the oldest near cluster
            S_HIT:
            begin
                cmp_next = '0;
                if (near_mask_reg == '0)
                begin
                    joined_next = 1'b0;
                    state_next  = S_COMPACT;
                end
                else
                begin
                    sel_a                        = first_set(near_mask_reg);
                    cell_op[sel_a]               = CELL_ABSORB;
                    load_rec                     = hit_rec;
                    load_rec.ovf                 = bank_full[cell_rec[sel_a].bank];
                    bank_cmd[cell_rec[sel_a].bank].append = 1'b1;
                    wr_data                      = ch_reg;
                    joined_next                  = 1'b1;
                    tgt_next                     = sel_a;
                    tgt_bank_next                = cell_rec[sel_a].bank;
                    src_mask_next = near_mask_reg & ~(MAX_OPEN'(1) << sel_a);
                    state_next    = S_MERGE;
                end
            end

            // younger near clusters fold into the target
            S_MERGE:
            begin
                cmp_next = '0;
                if (src_mask_reg == '0)
                begin
                    state_next = S_COMPACT;
                end
                else
                begin
                    sel_a            = first_set(src_mask_reg);
                    cell_op[tgt_reg] = CELL_ABSORB;
                    load_rec         = cell_rec[sel_a];
                    src_next         = sel_a;
                    src_bank_next    = cell_rec[sel_a].bank;
                    len_next         = bank_stored[cell_rec[sel_a].bank];
                    i_next           = '0;
                    state_next       = S_COPY;
                end
            end

            // channel copy, read then append in the following cycle
            S_COPY:
            begin
                copy_issue = (i_reg < len_reg);
                rd_addr    = i_reg[ADDR_W-1:0];
                pend_next  = copy_issue;
                if (copy_issue)
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    bank_cmd[tgt_bank_reg].append = 1'b1;
                    wr_data = bank_rdata[src_bank_reg];
                    if (bank_full[tgt_bank_reg])
                    begin
                        cell_op[tgt_reg] = CELL_SET_OVF;
                    end
                end
                if (!copy_issue && !pend_reg)
                begin
                    cell_op[src_reg] = CELL_KILL;
                    src_mask_next    = src_mask_reg & ~(MAX_OPEN'(1) << src_reg);
                    state_next       = S_MERGE;
                end
            end

            // odd-even exchange moves open clusters to the old end
            S_COMPACT:
            begin
                for (int k = 0; k < MAX_OPEN - 1; k++)
                begin
                    if ((1'(k) == cmp_reg[0]) && !valid_vec[k] && valid_vec[k+1])
                    begin
                        cell_op[k]   = CELL_TAKE_NEXT;
                        cell_op[k+1] = CELL_TAKE_PREV;
                    end
                end
                if (cmp_reg == SLOT_W'(MAX_OPEN - 1))
                begin
                    state_next = flush_reg ? S_IDLE : S_ALLOC;
                end
                else
                begin
                    cmp_next = cmp_reg + SLOT_W'(1);
                end
            end

            // unjoined hit opens the youngest cluster or is dropped
            S_ALLOC:
            begin
                if (!joined_reg)
                begin
                    if (!(&valid_vec))
                    begin
                        sel_a          = first_set(~valid_vec);
                        cell_op[sel_a] = CELL_LOAD;
                        load_rec       = hit_rec;
                        bank_cmd[cell_rec[sel_a].bank].init = 1'b1;
                        wr_data        = ch_reg;
                    end
                    else if (drop_reg != '1)
                    begin
                        drop_next = drop_reg + DROP_W'(1);
                    end
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            j_reg          <= '0;
            p_reg          <= '0;
            cmp_reg        <= '0;
            close_mask_reg <= '0;
            near_mask_reg  <= '0;
            emit_mask_reg  <= '0;
            src_mask_reg   <= '0;
            tgt_reg        <= '0;
            tgt_bank_reg   <= '0;
            src_reg        <= '0;
            src_bank_reg   <= '0;
            joined_reg     <= 1'b0;
            i_reg          <= '0;
            len_reg        <= '0;
            pend_reg       <= 1'b0;
            drop_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            j_reg          <= j_next;
            p_reg          <= p_next;
            cmp_reg        <= cmp_next;
            close_mask_reg <= close_mask_next;
            near_mask_reg  <= near_mask_next;
            emit_mask_reg  <= emit_mask_next;
            src_mask_reg   <= src_mask_next;
            tgt_reg        <= tgt_next;
            tgt_bank_reg   <= tgt_bank_next;
            src_reg        <= src_next;
            src_bank_reg   <= src_bank_next;
            joined_reg     <= joined_next;
            i_reg          <= i_next;
            len_reg        <= len_next;
            pend_reg       <= pend_next;
            drop_reg       <= drop_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_rec_reg  <= cell_rec[p_reg];
            out_drop_reg <= drop_reg;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign member_count   = out_rec_reg.hits;
    assign adc_total      = out_rec_reg.adc_sum;
    assign first_time     = out_rec_reg.start_time;
    assign last_time      = out_rec_reg.end_time;
    assign channel_low    = out_rec_reg.chan_low;
    assign channel_high   = out_rec_reg.chan_high;
    assign store_overflow = out_rec_reg.ovf;
    assign dropped_hits   = out_drop_reg;
    assign last_of_run    = out_last_reg;

    // every bank belongs to exactly one cell
    always_comb
    begin
        bank_used = '0;
        for (int k = 0; k < MAX_OPEN; k++)
        begin
            bank_used[cell_rec[k].bank] = 1'b1;
        end
    end

    // checks
    a_banks_unique: assert property (@(posedge clk) disable iff (!rst_n)
        &bank_used)
        else $error("bank pointers not a permutation");

    a_compacted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC) |-> ((valid_vec & (valid_vec + MAX_OPEN'(1))) == '0))
        else $error("open clusters not packed at allocation");

    a_copy_banks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY) |-> (tgt_bank_reg != src_bank_reg))
        else $error("merge copies a bank onto itself");

    a_target_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> (cell_rec[tgt_reg].valid && !close_mask_reg[tgt_reg]))
        else $error("merge target is not an open cluster");

endmodule

`default_nettype wire

// ----- rtl/tchc_bank.sv -----
// ============================================================================
// tchc_bank: member channel store of one cluster
// Holds up to MAX_MEMBERS channels, appends, and runs the adjacency scan.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tchc_bank (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tchc_pkg::bank_cmd_t           cmd,
    input  logic [tchc_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [tchc_pkg::CHAN_W-1:0]   wr_data,
    input  logic [tchc_pkg::CHAN_W-1:0]   hit_channel,
    input  logic [tchc_pkg::CHAN_W-1:0]   chan_gap,
    output logic [tchc_pkg::CHAN_W-1:0]   rd_data,
    output logic                          near,
    output logic                          full,
    output logic [tchc_pkg::CNT_W-1:0]    stored
);
    import tchc_pkg::*;

    logic [CHAN_W-1:0] mem [MAX_MEMBERS];
    logic [CHAN_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] addr_d_reg;
    logic [CNT_W-1:0]  stored_reg, stored_next;
    logic              near_reg, near_next;
    logic              scan_d_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAN_W-1:0] chan_diff;

    assign full    = (stored_reg == CNT_W'(MAX_MEMBERS));
    assign wr_en   = cmd.init || (cmd.append && !full);
    assign wr_addr = cmd.init ? '0 : stored_reg[ADDR_W-1:0];

    // storage, registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        addr_d_reg  <= rd_addr;
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // distance of the scanned member to the hit channel
    always_comb
    begin
        chan_diff = (rd_data_reg > hit_channel) ? (rd_data_reg - hit_channel)
                                                : (hit_channel - rd_data_reg);
    end

    // fill count and adjacency flag
    always_comb
    begin
        stored_next = stored_reg;
        if (cmd.init)
        begin
            stored_next = CNT_W'(1);
        end
        else if (cmd.append && !full)
        begin
            stored_next = stored_reg + CNT_W'(1);
        end

        near_next = near_reg;
        if (cmd.scan_clr)
        begin
            near_next = 1'b0;
        end
        else if (scan_d_reg && (CNT_W'(addr_d_reg) < stored_reg) && (chan_diff <= chan_gap))
        begin
            near_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
            near_reg   <= 1'b0;
            scan_d_reg <= 1'b0;
        end
        else
        begin
            stored_reg <= stored_next;
            near_reg   <= near_next;
            scan_d_reg <= cmd.scan_en;
        end
    end

    assign rd_data = rd_data_reg;
    assign near    = near_reg;
    assign stored  = stored_reg;

endmodule

`default_nettype wire

// ----- rtl/tchc_cell.sv -----
// ============================================================================
// tchc_cell: one age position of the open cluster chain
// Holds a cluster summary, tests it against the hit, absorbs hits and
// merged clusters, and swaps with its neighbors during compaction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tchc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tchc_pkg::SLOT_W-1:0]   reset_bank,
    input  tchc_pkg::cell_op_t            op,
    input  tchc_pkg::cluster_rec_t        load_rec,
    input  tchc_pkg::cluster_rec_t        prev_rec,
    input  tchc_pkg::cluster_rec_t        next_rec,
    input  logic [tchc_pkg::TIME_W-1:0]   hit_start,
    input  logic [tchc_pkg::TICK_W-1:0]   tick_gap,
    input  logic [tchc_pkg::HITS_W-1:0]   min_hits,
    input  logic [tchc_pkg::SUM_W-1:0]    adc_cut,
    input  logic [tchc_pkg::MAX_OPEN-1:0] bank_near,
    output tchc_pkg::cluster_rec_t        rec,
    output logic                          closing,
    output logic                          qualified,
    output logic                          near
);
    import tchc_pkg::*;

    cluster_rec_t      rec_reg, rec_next, merged;
    cluster_rec_t      reset_rec;
    logic [HITS_W:0]   hit_sum;
    logic [SUM_W:0]    adc_sum;
    logic [TIME_W-1:0] gap;

    // empty record that owns this position's bank
    always_comb
    begin
        reset_rec      = '0;
        reset_rec.bank = reset_bank;
    end

    // merge of load_rec into this cluster, saturating sums
    always_comb
    begin
        hit_sum = {1'b0, rec_reg.hits} + {1'b0, load_rec.hits};
        adc_sum = {1'b0, rec_reg.adc_sum} + {1'b0, load_rec.adc_sum};
        merged  = rec_reg;
        merged.hits       = hit_sum[HITS_W] ? '1 : hit_sum[HITS_W-1:0];
        merged.adc_sum    = adc_sum[SUM_W] ? '1 : adc_sum[SUM_W-1:0];
        merged.start_time = (load_rec.start_time < rec_reg.start_time) ?
                            load_rec.start_time : rec_reg.start_time;
        merged.end_time   = (load_rec.end_time > rec_reg.end_time) ?
                            load_rec.end_time : rec_reg.end_time;
        merged.chan_low   = (load_rec.chan_low < rec_reg.chan_low) ?
                            load_rec.chan_low : rec_reg.chan_low;
        merged.chan_high  = (load_rec.chan_high > rec_reg.chan_high) ?
                            load_rec.chan_high : rec_reg.chan_high;
        merged.ovf        = rec_reg.ovf | load_rec.ovf;
    end

    // tests against the current hit and the emit cut
    always_comb
    begin
        gap       = hit_start - rec_reg.end_time;
        closing   = rec_reg.valid && (hit_start > rec_reg.end_time) &&
                    (gap > {{(TIME_W-TICK_W){1'b0}}, tick_gap});
        qualified = (rec_reg.hits >= min_hits) && (rec_reg.adc_sum > adc_cut);
        near      = rec_reg.valid && bank_near[rec_reg.bank];
    end

    // next record
    always_comb
    begin
        rec_next = rec_reg;
        unique case (op)
            CELL_HOLD:      rec_next = rec_reg;
            CELL_TAKE_PREV: rec_next = prev_rec;
            CELL_TAKE_NEXT: rec_next = next_rec;
            CELL_LOAD:
            begin
                rec_next       = load_rec;
                rec_next.valid = 1'b1;
                rec_next.bank  = rec_reg.bank;
            end
            CELL_ABSORB:    rec_next = merged;
            CELL_KILL:      rec_next.valid = 1'b0;
            CELL_SET_OVF:   rec_next.ovf = 1'b1;
            default:        rec_next = rec_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= reset_rec;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

`default_nettype wire
